// File: hdl/hrrn_process_scheduler_macros.svh
// ---------------------------------------------------------------------------
// HRRN scheduler assertion macros
// Shorthand for clocked concurrent assertions, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef HRRN_PROCESS_SCHEDULER_MACROS_SVH
`define HRRN_PROCESS_SCHEDULER_MACROS_SVH

// property holds at every clock edge out of reset
`define HRRN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// trigger now implies consequence in the next cycle
`define HRRN_ASSERT_NEXT(label, trig, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (conseq)) \
        else $error(msg);

`endif

// File: hdl/hrrn_pkg.sv
// ---------------------------------------------------------------------------
// HRRN scheduler package
// Widths, table entry layout, command codes and sequencer states.
// ---------------------------------------------------------------------------
package hrrn_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W   = 8;
    localparam int TIME_W = 32;
    localparam int LEN_W  = 16;
    localparam int NUM_W  = TIME_W + 1;        // wait + length
    localparam int PROD_W = NUM_W + LEN_W;     // cross product

    localparam int IN_FIELDS_W = ID_W + TIME_W + LEN_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + ID_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_ARRIVE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [TIME_W-1:0] arrival;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_NUM,
        ST_MUL_A,
        ST_MUL_B,
        ST_CMP,
        ST_PICK,
        ST_SH_RD,
        ST_SH_WR,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

// File: hdl/hrrn_ram.sv
// ---------------------------------------------------------------------------
// HRRN generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module hrrn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/hrrn_xmul.sv
// ---------------------------------------------------------------------------
// HRRN cross multiplier
// Shared ratio-numerator by length multiplier, product registered.
// ---------------------------------------------------------------------------
module hrrn_xmul (
    input  logic                          clk,
    input  logic                          en,
    input  logic [hrrn_pkg::NUM_W-1:0]    op_a,
    input  logic [hrrn_pkg::LEN_W-1:0]    op_b,
    output logic [hrrn_pkg::PROD_W-1:0]   prod
);

    logic [hrrn_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= hrrn_pkg::PROD_W'(op_a) * hrrn_pkg::PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

// File: hdl/hrrn_process_scheduler.sv
// ---------------------------------------------------------------------------
// HRRN process scheduler
// Non-preemptive highest-response-ratio-next scheduler with a RAM ready table.
// ---------------------------------------------------------------------------
// Sequence: an arrival, or a tick that needs no pick, goes to ST_DONE, which loads
// the output register; a tick that picks reads each queued entry (ST_READ, ST_LOAD,
// ST_NUM), sends each further one through the shared cross multiplier (ST_MUL_A,
// ST_MUL_B, ST_CMP), starts the pick (ST_PICK), moves each entry behind the pick
// up (ST_SH_RD, ST_SH_WR), drops the count (ST_FIN) and loads the output register.
// One request at a time; the next is taken while the last result waits.
// Reset clears the control state only; the table RAM is not cleared.
module hrrn_process_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] proc_id, [39:8] arrival_time, [55:40] service_length
    input  logic [hrrn_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] running_valid, [8:1] running_id, [9] rejected, [15:10] zero
    output logic [hrrn_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // -----------------------------------------------------------------------
    // Request fields
    // -----------------------------------------------------------------------
    logic                         in_fire;
    hrrn_pkg::cmd_t               in_cmd;
    logic [hrrn_pkg::ID_W-1:0]    in_id;
    logic [hrrn_pkg::TIME_W-1:0]  in_arrival;
    logic [hrrn_pkg::LEN_W-1:0]   in_len;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign in_cmd     = hrrn_pkg::cmd_t'(s_axis_tuser[0]);
    assign in_id      = s_axis_tdata[hrrn_pkg::ID_W-1:0];
    assign in_arrival = s_axis_tdata[hrrn_pkg::ID_W+hrrn_pkg::TIME_W-1:hrrn_pkg::ID_W];
    assign in_len     = s_axis_tdata[hrrn_pkg::IN_FIELDS_W-1:hrrn_pkg::ID_W+hrrn_pkg::TIME_W];

    // -----------------------------------------------------------------------
    // State
    // -----------------------------------------------------------------------
    hrrn_pkg::state_t               state_reg, state_next;
    logic [hrrn_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [hrrn_pkg::TIME_W-1:0]    now_reg, now_next;
    logic                           run_valid_reg, run_valid_next;
    logic [hrrn_pkg::ID_W-1:0]      run_id_reg, run_id_next;
    logic [hrrn_pkg::LEN_W-1:0]     run_rem_reg, run_rem_next;

    // scan / shift index and the entry under test
    logic [hrrn_pkg::ADDR_W-1:0]    idx_reg, idx_next;
    logic [hrrn_pkg::ID_W-1:0]      cur_id_reg, cur_id_next;
    logic [hrrn_pkg::LEN_W-1:0]     cur_len_reg, cur_len_next;
    logic [hrrn_pkg::TIME_W-1:0]    cur_wait_reg, cur_wait_next;
    logic [hrrn_pkg::NUM_W-1:0]     cur_num_reg, cur_num_next;

    // best entry so far
    logic [hrrn_pkg::ID_W-1:0]      best_id_reg, best_id_next;
    logic [hrrn_pkg::LEN_W-1:0]     best_len_reg, best_len_next;
    logic [hrrn_pkg::NUM_W-1:0]     best_num_reg, best_num_next;
    logic [hrrn_pkg::ADDR_W-1:0]    best_idx_reg, best_idx_next;

    logic [hrrn_pkg::PROD_W-1:0]    lhs_reg, lhs_next;
    logic                           rej_reg, rej_next;

    // output register
    logic                           out_valid_reg, out_valid_next;
    logic                           out_rv_reg, out_rv_next;
    logic [hrrn_pkg::ID_W-1:0]      out_id_reg, out_id_next;
    logic                           out_rej_reg, out_rej_next;

    // -----------------------------------------------------------------------
    // Table RAM and shared multiplier
    // -----------------------------------------------------------------------
    logic                           ram_wr_en;
    logic [hrrn_pkg::ADDR_W-1:0]    ram_wr_addr;
    hrrn_pkg::entry_t               ram_wr_data;
    logic [hrrn_pkg::ADDR_W-1:0]    ram_rd_addr;
    hrrn_pkg::entry_t               ram_rd_data;

    logic                           mul_en;
    logic [hrrn_pkg::NUM_W-1:0]     mul_a;
    logic [hrrn_pkg::LEN_W-1:0]     mul_b;
    logic [hrrn_pkg::PROD_W-1:0]    prod;

    hrrn_ram #(
        .WIDTH ($bits(hrrn_pkg::entry_t)),
        .DEPTH (hrrn_pkg::QUEUE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    hrrn_xmul u_xmul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // -----------------------------------------------------------------------
    // Shared conditions
    // -----------------------------------------------------------------------
    logic                           table_full;
    logic                           in_reject;
    logic                           needs_pick;
    logic [hrrn_pkg::TIME_W-1:0]    now_inc;
    logic [hrrn_pkg::CNT_W-1:0]     idx_inc;
    logic [hrrn_pkg::CNT_W-1:0]     idx_inc2;
    logic [hrrn_pkg::CNT_W-1:0]     best_inc;
    logic                           more_scan;
    logic [hrrn_pkg::NUM_W-1:0]     num_sum;
    logic                           out_load;

    assign table_full = (count_reg == hrrn_pkg::CNT_W'(hrrn_pkg::QUEUE_DEPTH));
    assign in_reject  = table_full || (in_len == '0);
    assign needs_pick = !run_valid_reg || (run_rem_reg == '0);
    // clock saturates at all ones
    assign now_inc    = (now_reg == '1) ? now_reg : now_reg + hrrn_pkg::TIME_W'(1);
    assign idx_inc    = hrrn_pkg::CNT_W'(idx_reg) + hrrn_pkg::CNT_W'(1);
    assign idx_inc2   = hrrn_pkg::CNT_W'(idx_reg) + hrrn_pkg::CNT_W'(2);
    assign best_inc   = hrrn_pkg::CNT_W'(best_idx_reg) + hrrn_pkg::CNT_W'(1);
    assign more_scan  = (idx_inc < count_reg);
    assign num_sum    = {1'b0, cur_wait_reg} + hrrn_pkg::NUM_W'(cur_len_reg);
    assign out_load   = (state_reg == hrrn_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);

    // -----------------------------------------------------------------------
    // Sequencer: next state
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hrrn_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd == hrrn_pkg::CMD_TICK && needs_pick && count_reg != '0)
                    begin
                        state_next = hrrn_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = hrrn_pkg::ST_DONE;
                    end
                end
            end
            hrrn_pkg::ST_READ:  state_next = hrrn_pkg::ST_LOAD;
            hrrn_pkg::ST_LOAD:  state_next = hrrn_pkg::ST_NUM;
            hrrn_pkg::ST_NUM:
            begin
                if (idx_reg != '0)
                begin
                    state_next = hrrn_pkg::ST_MUL_A;
                end
                else
                begin
                    state_next = more_scan ? hrrn_pkg::ST_READ : hrrn_pkg::ST_PICK;
                end
            end
            hrrn_pkg::ST_MUL_A: state_next = hrrn_pkg::ST_MUL_B;
            hrrn_pkg::ST_MUL_B: state_next = hrrn_pkg::ST_CMP;
            hrrn_pkg::ST_CMP:
            begin
                state_next = more_scan ? hrrn_pkg::ST_READ : hrrn_pkg::ST_PICK;
            end
            hrrn_pkg::ST_PICK:
            begin
                state_next = (best_inc < count_reg) ? hrrn_pkg::ST_SH_RD : hrrn_pkg::ST_FIN;
            end
            hrrn_pkg::ST_SH_RD: state_next = hrrn_pkg::ST_SH_WR;
            hrrn_pkg::ST_SH_WR:
            begin
                state_next = (idx_inc2 < count_reg) ? hrrn_pkg::ST_SH_RD : hrrn_pkg::ST_FIN;
            end
            hrrn_pkg::ST_FIN:   state_next = hrrn_pkg::ST_DONE;
            hrrn_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = hrrn_pkg::ST_IDLE;
                end
            end
            default:            state_next = hrrn_pkg::ST_IDLE;
        endcase
    end

    // -----------------------------------------------------------------------
    // Sequencer: outputs to RAM, multiplier and request port
    // -----------------------------------------------------------------------
    always_comb
    begin
        s_axis_tready = (state_reg == hrrn_pkg::ST_IDLE);
        ram_wr_en     = 1'b0;
        ram_wr_addr   = idx_reg;
        ram_wr_data   = ram_rd_data;
        ram_rd_addr   = idx_reg;
        mul_en        = 1'b0;
        mul_a         = cur_num_reg;
        mul_b         = best_len_reg;
        unique case (state_reg)
            hrrn_pkg::ST_IDLE:
            begin
                // append at the tail
                ram_wr_en   = in_fire && (in_cmd == hrrn_pkg::CMD_ARRIVE) && !in_reject;
                ram_wr_addr = count_reg[hrrn_pkg::ADDR_W-1:0];
                ram_wr_data = '{length: in_len, arrival: in_arrival, id: in_id};
            end
            hrrn_pkg::ST_MUL_A:
            begin
                // candidate numerator times best length
                mul_en = 1'b1;
            end
            hrrn_pkg::ST_MUL_B:
            begin
                // best numerator times candidate length
                mul_en = 1'b1;
                mul_a  = best_num_reg;
                mul_b  = cur_len_reg;
            end
            hrrn_pkg::ST_SH_RD:
            begin
                ram_rd_addr = idx_inc[hrrn_pkg::ADDR_W-1:0];
            end
            hrrn_pkg::ST_SH_WR:
            begin
                // close the gap: entry idx+1 moves to idx
                ram_wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Datapath next values
    // -----------------------------------------------------------------------
    always_comb
    begin
        count_next     = count_reg;
        now_next       = now_reg;
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        run_rem_next   = run_rem_reg;
        idx_next       = idx_reg;
        cur_id_next    = cur_id_reg;
        cur_len_next   = cur_len_reg;
        cur_wait_next  = cur_wait_reg;
        cur_num_next   = cur_num_reg;
        best_id_next   = best_id_reg;
        best_len_next  = best_len_reg;
        best_num_next  = best_num_reg;
        best_idx_next  = best_idx_reg;
        lhs_next       = lhs_reg;
        rej_next       = rej_reg;

        unique case (state_reg)
            hrrn_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next = '0;
                    if (in_cmd == hrrn_pkg::CMD_ARRIVE)
                    begin
                        rej_next = in_reject;
                        if (!in_reject)
                        begin
                            count_next = count_reg + hrrn_pkg::CNT_W'(1);
                        end
                    end
                    else
                    begin
                        rej_next = 1'b0;
                        if (!needs_pick)
                        begin
                            run_rem_next = run_rem_reg - hrrn_pkg::LEN_W'(1);
                            now_next     = now_inc;
                        end
                        else if (count_reg == '0)
                        begin
                            // empty table: processor goes idle
                            run_valid_next = 1'b0;
                            run_id_next    = '0;
                            now_next       = now_inc;
                        end
                    end
                end
            end
            hrrn_pkg::ST_LOAD:
            begin
                cur_id_next  = ram_rd_data.id;
                cur_len_next = ram_rd_data.length;
                // an arrival in the future waits nothing
                cur_wait_next = (now_reg > ram_rd_data.arrival) ?
                                now_reg - ram_rd_data.arrival : '0;
            end
            hrrn_pkg::ST_NUM:
            begin
                cur_num_next = num_sum;
                if (idx_reg == '0)
                begin
                    best_id_next  = cur_id_reg;
                    best_len_next = cur_len_reg;
                    best_num_next = num_sum;
                    best_idx_next = idx_reg;
                    if (more_scan)
                    begin
                        idx_next = idx_inc[hrrn_pkg::ADDR_W-1:0];
                    end
                end
            end
            hrrn_pkg::ST_MUL_B:
            begin
                lhs_next = prod;
            end
            hrrn_pkg::ST_CMP:
            begin
                // strictly greater: the earlier entry keeps a tie
                if (lhs_reg > prod)
                begin
                    best_id_next  = cur_id_reg;
                    best_len_next = cur_len_reg;
                    best_num_next = cur_num_reg;
                    best_idx_next = idx_reg;
                end
                if (more_scan)
                begin
                    idx_next = idx_inc[hrrn_pkg::ADDR_W-1:0];
                end
            end
            hrrn_pkg::ST_PICK:
            begin
                // length is nonzero, so the first tick of work is taken now
                run_valid_next = 1'b1;
                run_id_next    = best_id_reg;
                run_rem_next   = best_len_reg - hrrn_pkg::LEN_W'(1);
                now_next       = now_inc;
                idx_next       = best_idx_reg;
            end
            hrrn_pkg::ST_SH_WR:
            begin
                idx_next = idx_inc[hrrn_pkg::ADDR_W-1:0];
            end
            hrrn_pkg::ST_FIN:
            begin
                count_next = count_reg - hrrn_pkg::CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // output register, filled when the previous result has gone
    always_comb
    begin
        out_rv_next  = out_rv_reg;
        out_id_next  = out_id_reg;
        out_rej_next = out_rej_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_rv_next    = run_valid_reg;
            out_id_next    = run_valid_reg ? run_id_reg : '0;
            out_rej_next   = rej_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrrn_pkg::ST_IDLE;
            count_reg     <= '0;
            now_reg       <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_rem_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            now_reg       <= now_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            run_rem_reg   <= run_rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        cur_id_reg   <= cur_id_next;
        cur_len_reg  <= cur_len_next;
        cur_wait_reg <= cur_wait_next;
        cur_num_reg  <= cur_num_next;
        best_id_reg  <= best_id_next;
        best_len_reg <= best_len_next;
        best_num_reg <= best_num_next;
        best_idx_reg <= best_idx_next;
        lhs_reg      <= lhs_next;
        rej_reg      <= rej_next;
        out_rv_reg   <= out_rv_next;
        out_id_reg   <= out_id_next;
        out_rej_reg  <= out_rej_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(hrrn_pkg::OUT_TDATA_W - hrrn_pkg::OUT_FIELDS_W)'(0),
                            out_rej_reg, out_id_reg, out_rv_reg};

endmodule

// File: hdl/hrrn_checker.sv
// ---------------------------------------------------------------------------
// HRRN scheduler port checker
// Watches the stream ports of the scheduler; bound to the top level.
// ---------------------------------------------------------------------------
`include "hrrn_process_scheduler_macros.svh"

module hrrn_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [hrrn_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // requests taken but not yet answered
    logic [1:0] pend_reg, pend_next;
    logic       in_fire;
    logic       out_fire;
    logic       out_stall;
    logic       pend_some;
    logic       idle_shown;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_fire   = m_axis_tvalid && m_axis_tready;
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign pend_some  = (pend_reg != 2'd0);
    assign idle_shown = m_axis_tvalid && !m_axis_tdata[0];

    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire && !out_fire)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (out_fire && !in_fire)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `HRRN_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "not held")
    `HRRN_ASSERT_NEXT(a_busy_after_take, in_fire, !s_axis_tready, "busy after take")
    `HRRN_ASSERT(a_no_extra_result, !m_axis_tvalid || pend_some, "orphan result")
    `HRRN_ASSERT(a_pend_bound, pend_reg != 2'd3, "over two in flight")
    `HRRN_ASSERT(a_idle_id_zero, !idle_shown || (m_axis_tdata[8:1] == 8'd0), "idle id set")

endmodule

bind hrrn_process_scheduler hrrn_checker u_checker (.*);
